// ===== rtl/dipole_field_accumulator_unit_macros.svh =====
// Assertion macros used by the dipole field accumulator back end.
`ifndef DIPOLE_FIELD_ACCUMULATOR_UNIT_MACROS_SVH
`define DIPOLE_FIELD_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define DFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfa: same-cycle check failed");

// Next-cycle implication, checked on clk outside of reset.
`define DFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfa: next-cycle check failed");

`endif

// ===== rtl/dfa_pkg.sv =====
// Types and constants shared by the dipole field accumulator modules.
package dfa_pkg;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic signed [15:0] moment_x;
    logic signed [15:0] moment_y;
    logic signed [15:0] moment_z;
    logic               last_source;
  } dfa_in_t;

  typedef struct packed {
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
  } dfa_out_t;

  // Classified request: normalized separation, moment and exponent.
  typedef struct packed {
    logic             zero;
    logic             last;
    logic [2:0][16:0] a;
    logic [2:0][15:0] m;
    logic signed [5:0] e;
  } dfa_work_t;

  typedef struct packed {
    logic        start;
    logic [62:0] dividend;
    logic [33:0] divisor;
  } dfa_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [62:0] quotient;
  } dfa_div_rsp_t;

  localparam logic [63:0] SUM_MAX64 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN   = 48'h8000_0000_0000;

endpackage

// ===== rtl/dipole_field_accumulator_unit.sv =====
// Dipole field accumulator top level. Each request pairs a target with one
// source dipole; the front end forms and normalizes the separation and
// queues it, and the back end evaluates the term, adds it into three
// saturating Q24.24 sums and, on a request marked last, delivers the field
// and clears the sums. A coincident pair goes straight from idle to the
// accumulate state in the back end; any other pair is bounded by the shared
// one-bit-per-cycle divider (63 steps, used four times per term) and the
// 32-step square root. The front end keeps accepting requests while
// the queue has room, and a finished field waits in its own output register.
module dipole_field_accumulator_unit import dfa_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  dfa_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output dfa_out_t result
);

  dfa_work_t    work;
  dfa_work_t    head;
  logic         push;
  logic         full;
  logic         pop;
  logic         empty;
  dfa_div_req_t div_req;
  dfa_div_rsp_t div_rsp;

  dfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .work       (work),
    .full       (full)
  );

  dfa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (work),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .empty (empty)
  );

  dfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dfa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/dfa_front.sv =====
// Front end: takes requests, forms the separation and normalizes it.
module dfa_front import dfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  dfa_in_t   item,
  output logic      push,
  output dfa_work_t work,
  input  logic      full
);

  dfa_in_t held;
  logic    held_valid;

  logic [2:0][32:0] r;
  logic [2:0][32:0] rm;
  logic [32:0]      mx;
  logic [5:0]       blen;
  logic [5:0]       nsh;

  function automatic logic [5:0] bit_length(input logic [32:0] v);
    logic [5:0] n;
    n = '0;
    for (int k = 0; k < 33; k++) begin
      if (v[k]) n = 6'(k + 1);
    end
    return n;
  endfunction

  always_comb begin
    r[0] = {held.target_x[31], held.target_x} - {held.source_x[31], held.source_x};
    r[1] = {held.target_y[31], held.target_y} - {held.source_y[31], held.source_y};
    r[2] = {held.target_z[31], held.target_z} - {held.source_z[31], held.source_z};
    for (int k = 0; k < 3; k++) begin
      rm[k] = r[k][32] ? -r[k] : r[k];
    end
    mx = rm[0];
    if (rm[1] > mx) mx = rm[1];
    if (rm[2] > mx) mx = rm[2];
    blen = bit_length(mx);
    work.zero = (mx == '0);
    work.last = held.last_source;
    work.m[0] = held.moment_x;
    work.m[1] = held.moment_y;
    work.m[2] = held.moment_z;
    work.e    = $signed(blen) - 6'sd16;
    nsh       = (blen >= 6'd16) ? (blen - 6'd16) : (6'd16 - blen);
    for (int k = 0; k < 3; k++) begin
      logic [32:0] am;
      am = (blen >= 6'd16) ? (rm[k] >> nsh) : (rm[k] << nsh);
      work.a[k] = r[k][32] ? -{1'b0, am[15:0]} : {1'b0, am[15:0]};
    end
  end

  assign push       = held_valid && !full;
  assign item_ready = !held_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        held_valid <= 1'b1;
      end else if (push) begin
        held_valid <= 1'b0;
      end
    end
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

// ===== rtl/dfa_fifo.sv =====
// Short queue of classified requests between the front and back ends.
module dfa_fifo import dfa_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dfa_work_t wdata,
  output logic      full,
  input  logic      pop,
  output dfa_work_t rdata,
  output logic      empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dfa_work_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/dfa_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
module dfa_div import dfa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  dfa_div_req_t req,
  output dfa_div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [62:0] dvd;
  logic [33:0] dsr;
  logic [33:0] rem;
  logic [62:0] quo;
  logic [34:0] trial;
  logic        ge;

  assign trial = {rem, dvd[62]};
  assign ge    = trial >= {1'b0, dsr};

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 6'd62);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd62) begin
        busy <= 1'b0;
      end
    end
    if (req.start) begin
      cnt <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      dvd <= {dvd[61:0], 1'b0};
      rem <= ge ? 34'(trial - {1'b0, dsr}) : trial[33:0];
      quo <= {quo[61:0], ge};
    end
  end

endmodule

// ===== rtl/dfa_back.sv =====
// Back end: evaluates one dipole term at a time and keeps the field sums.
`include "dipole_field_accumulator_unit_macros.svh"
module dfa_back import dfa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         empty,
  input  dfa_work_t    head,
  output logic         pop,
  output dfa_div_req_t div_req,
  input  dfa_div_rsp_t div_rsp,
  output logic         result_valid,
  input  logic         result_ready,
  output dfa_out_t     result
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_DIVU, S_DOT, S_CUBE1, S_CUBE2, S_DIVR,
    S_V, S_P, S_H, S_ACC
  } state_t;

  state_t            state;
  logic [1:0]        idx;
  dfa_work_t         cur;
  logic [33:0]       l2;
  logic [61:0]       sq_v;
  logic [63:0]       sq_res;
  logic [63:0]       sq_bit;
  logic              div_wait;
  logic [2:0][32:0]  u;
  logic signed [50:0] dot;
  logic signed [21:0] dq;
  logic [37:0]       s2;
  logic [33:0]       c32;
  logic [34:0]       rc;
  logic [31:0]       wm;
  logic              w_neg;
  logic [63:0]       p;
  logic [2:0][47:0]  h;
  logic [2:0][47:0]  sum;

  logic [16:0]       a_sel;
  logic [15:0]       a_mag;
  logic [63:0]       rb;
  logic              sq_ge;
  logic signed [48:0] mu_prod;
  logic [50:0]       dot_mag;
  logic [20:0]       dq_mag;
  logic signed [54:0] uv;
  logic signed [57:0] uv58;
  logic signed [57:0] m58;
  logic signed [57:0] v;
  logic [57:0]       v_mag;
  logic [61:0]       ss;
  logic [60:0]       cc;
  logic signed [7:0] e8;
  logic signed [7:0] sh;
  logic [7:0]        nr;
  logic [63:0]       t_pos;
  logic [63:0]       t_neg;
  logic [63:0]       t;
  logic [2:0][47:0]  sum_new;
  logic              res_free;
  logic              emit;

  always_comb begin
    a_sel   = cur.a[idx];
    a_mag   = a_sel[16] ? 16'(-a_sel) : a_sel[15:0];
    rb      = sq_res + sq_bit;
    sq_ge   = {2'b00, sq_v} >= rb;
    mu_prod = $signed(cur.m[idx]) * $signed(u[idx]);
    dot_mag = dot[50] ? 51'(-dot) : 51'(dot);
    dq_mag  = dot_mag[50:30];
    uv      = $signed(u[idx]) * dq;
    uv58    = {{3{uv[54]}}, uv};
    m58     = {{42{cur.m[idx][15]}}, cur.m[idx]};
    v       = (uv58 <<< 1) + uv58 - (m58 <<< 30);
    v_mag   = v[57] ? 58'(-v) : 58'(v);
    ss      = sq_res[30:0] * sq_res[30:0];
    cc      = s2 * sq_res[30:8];
    e8      = {{2{cur.e[5]}}, cur.e};
    sh      = -8'sd30 - (e8 + e8 + e8);
    nr      = 8'(-sh);
    t_pos   = (p > (SUM_MAX64 >> sh[3:0])) ? SUM_MAX64 : (p << sh[3:0]);
    t_neg   = (nr >= 8'd64) ? 64'd0 : (p >> nr[5:0]);
    if (t_neg > SUM_MAX64) t_neg = SUM_MAX64;
    t = sh[7] ? t_neg : t_pos;
    for (int k = 0; k < 3; k++) begin
      logic [48:0] s49;
      s49 = {sum[k][47], sum[k]} + {h[k][47], h[k]};
      if (s49[48] != s49[47]) begin
        sum_new[k] = s49[48] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_new[k] = s49[47:0];
      end
    end
    res_free = !result_valid || result_ready;
    emit     = (state == S_ACC) && cur.last && res_free;
  end

  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    div_req.start    = ((state == S_DIVU) || (state == S_DIVR)) && !div_wait;
    div_req.dividend = (state == S_DIVR) ? {1'b1, 62'd0} : {3'd0, a_mag, 44'd0};
    div_req.divisor  = (state == S_DIVR) ? c32 : {3'd0, sq_res[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      div_wait     <= 1'b0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cur <= head;
            idx <= '0;
            l2  <= '0;
            if (head.zero) begin
              h     <= '0;
              state <= S_ACC;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (idx == 2'd2) begin
            sq_v   <= {34'(l2 + 34'(a_mag * a_mag)), 28'd0};
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            idx    <= '0;
            state  <= S_SQRT;
          end else begin
            l2  <= l2 + 34'(a_mag * a_mag);
            idx <= idx + 1'b1;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v   <= 62'(sq_v - rb);
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            state <= S_DIVU;
          end
        end
        S_DIVU: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            u[idx]   <= a_sel[16] ? -{1'b0, div_rsp.quotient[31:0]}
                                  : {1'b0, div_rsp.quotient[31:0]};
            if (idx == 2'd2) begin
              idx   <= '0;
              dot   <= '0;
              state <= S_DOT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_DOT: begin
          dot <= dot + mu_prod;
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_CUBE1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CUBE1: begin
          dq    <= dot[50] ? -{1'b0, dq_mag} : {1'b0, dq_mag};
          s2    <= ss[61:24];
          state <= S_CUBE2;
        end
        S_CUBE2: begin
          c32   <= (cc[60:27] == '0) ? 34'd1 : cc[60:27];
          state <= S_DIVR;
        end
        S_DIVR: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            rc       <= div_rsp.quotient[34:0];
            state    <= S_V;
          end
        end
        S_V: begin
          // The magnitude of w stays well below 2^29 for every input.
          wm    <= v_mag[50:19];
          w_neg <= v[57];
          state <= S_P;
        end
        S_P: begin
          p     <= 64'(wm * rc);
          state <= S_H;
        end
        S_H: begin
          h[idx] <= w_neg ? 48'(-t[47:0]) : t[47:0];
          if (idx == 2'd2) begin
            idx   <= '0;
            state <= S_ACC;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_V;
          end
        end
        S_ACC: begin
          if (!cur.last) begin
            sum   <= sum_new;
            state <= S_IDLE;
          end else if (res_free) begin
            result.field_x <= sum_new[0];
            result.field_y <= sum_new[1];
            result.field_z <= sum_new[2];
            sum            <= '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DFA_ASSERT_IMP(a_div_idle, div_req.start, !div_rsp.busy)
  `DFA_ASSERT_NXT(a_sum_clear, (state == S_ACC) && cur.last && res_free, sum == '0)
  `DFA_ASSERT_IMP(a_root_range, state == S_CUBE1, (sq_res[63:31] == '0) && (sq_res[30] || sq_res[29]))

endmodule

// ===== tb/dipole_field_accumulator_unit_test.sv =====
// Self-checking testbench for the dipole field accumulator unit.
`timescale 1ns / 1ps

module dipole_field_accumulator_unit_test;
  import dfa_pkg::*;

  localparam longint FIELD_HI = 64'sd140737488355327;
  localparam longint FIELD_LO = -64'sd140737488355328;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 10000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    dfa_in_t  req;
    bit       known;
    dfa_out_t want;
  } row_t;

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_ready;
  dfa_in_t  item;
  logic     result_valid;
  logic     result_ready;
  dfa_out_t result;

  longint   field_sum [3];
  dfa_out_t field_q [$];
  dfa_out_t want_field;
  row_t     rows [$];
  int       errors;
  int       cycles;
  int       snd_idle;
  int       rcv_idle;
  bit       hold_req;

  dipole_field_accumulator_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned mag(longint x);
    return longint'(x < 0 ? -x : x);
  endfunction

  function automatic longint shr_tz(longint x, int n);
    longint unsigned q;
    q = mag(x) >> n;
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic int bit_length(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > FIELD_HI) return FIELD_HI;
    if (s < FIELD_LO) return FIELD_LO;
    return s;
  endfunction

  // Field of one dipole at the separation r, in Q24.24.
  function automatic void dipole_term(input longint r [3], input longint m [3],
                                      output longint h [3]);
    longint unsigned mx, l2, s, s2, c, c32, rc, q, p, t;
    longint a [3];
    longint u [3];
    longint dot, dq, v, w;
    int e, sh;
    mx = 0;
    l2 = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) if (mag(r[i]) > mx) mx = mag(r[i]);
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) h[i] = 0;
      return;
    end
    e = bit_length(mx) - 16;
    for (int i = 0; i < 3; i++) begin
      if (e >= 0) a[i] = shr_tz(r[i], e);
      else a[i] = r[i] * (longint'(1) << (-e));
      l2 = l2 + mag(a[i]) * mag(a[i]);
    end
    s = int_sqrt(l2 << 28);
    for (int i = 0; i < 3; i++) begin
      q = (mag(a[i]) << 44) / s;
      u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      dot = dot + m[i] * u[i];
    end
    dq = shr_tz(dot, 30);
    s2 = (s * s) >> 24;
    c = s2 * (s >> 8);
    c32 = c >> 27;
    if (c32 == 0) c32 = 1;
    rc = (64'd1 << 62) / c32;
    sh = -30 - 3 * e;
    for (int i = 0; i < 3; i++) begin
      v = 3 * u[i] * dq - m[i] * (longint'(1) << 30);
      w = shr_tz(v, 19);
      p = mag(w) * rc;
      if (sh >= 0) begin
        if (p > (SUM_MAX64 >> sh)) t = SUM_MAX64;
        else t = p << sh;
      end else begin
        t = (-sh >= 64) ? 64'd0 : (p >> (-sh));
        if (t > SUM_MAX64) t = SUM_MAX64;
      end
      h[i] = w < 0 ? -longint'(t) : longint'(t);
    end
  endfunction

  // Adds one pair into the running field and returns the field on a last request.
  function automatic void accumulate_field(input dfa_in_t req, output bit emitted,
                                           output dfa_out_t fld);
    longint r [3];
    longint m [3];
    longint h [3];
    r[0] = longint'(req.target_x) - longint'(req.source_x);
    r[1] = longint'(req.target_y) - longint'(req.source_y);
    r[2] = longint'(req.target_z) - longint'(req.source_z);
    m[0] = longint'(req.moment_x);
    m[1] = longint'(req.moment_y);
    m[2] = longint'(req.moment_z);
    dipole_term(r, m, h);
    for (int i = 0; i < 3; i++) field_sum[i] = clamp_add(field_sum[i], h[i]);
    emitted = req.last_source;
    fld.field_x = field_sum[0][47:0];
    fld.field_y = field_sum[1][47:0];
    fld.field_z = field_sum[2][47:0];
    if (req.last_source) for (int i = 0; i < 3; i++) field_sum[i] = 0;
  endfunction

  function automatic void add_row(int tx, int ty, int tz, int sx, int sy, int sz,
                                  shortint mx, shortint my, shortint mz, bit last,
                                  bit known);
    row_t rw;
    rw.req = '{tx, ty, tz, sx, sy, sz, mx, my, mz, last};
    rw.known = known;
    rw.want = '0;
    rows.insert(rows.size(), rw);
  endfunction

  function automatic dfa_in_t random_request();
    dfa_in_t rq;
    int unsigned mode;
    rq = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
    mode = $urandom_range(9);
    if (mode == 1) begin
      rq.source_x = rq.target_x;
      rq.source_y = rq.target_y;
      rq.source_z = rq.target_z;
    end else if (mode >= 2) begin
      // Nearby source: separations over a wide spread of magnitudes.
      rq.source_x = rq.target_x - (32'($urandom) >>> $urandom_range(31));
      rq.source_y = rq.target_y - (32'($urandom) >>> $urandom_range(31));
      rq.source_z = rq.target_z - (32'($urandom) >>> $urandom_range(31));
    end
    rq.last_source = ($urandom_range(3) == 0);
    return rq;
  endfunction

  // Drives one request; entered and left at a falling edge.
  task automatic send_request(input dfa_in_t rq, input bit known, input dfa_out_t want);
    bit emitted;
    dfa_out_t fld;
    while ($urandom_range(99) < snd_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= rq;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    accumulate_field(rq, emitted, fld);
    if (emitted) field_q.insert(field_q.size(), known ? want : fld);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    item_valid <= 1'b0;
    while (field_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(int count);
    dfa_out_t none;
    none = '0;
    for (int k = 0; k < count; k++) send_request(random_request(), 1'b0, none);
  endtask

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (field_q.size() == 0) begin
        $display("%0t: unexpected field %h", $time, result);
        errors++;
      end else begin
        want_field = field_q.pop_front();
        if (result.field_x !== want_field.field_x) begin
          $display("%0t: field_x expected %h actual %h", $time,
                   want_field.field_x, result.field_x);
          errors++;
        end
        if (result.field_y !== want_field.field_y) begin
          $display("%0t: field_y expected %h actual %h", $time,
                   want_field.field_y, result.field_y);
          errors++;
        end
        if (result.field_z !== want_field.field_z) begin
          $display("%0t: field_z expected %h actual %h", $time,
                   want_field.field_z, result.field_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL dipole_field_accumulator_unit");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    errors = 0;
    cycles = 0;
    hold_req = 1'b0;
    snd_idle = 0;
    rcv_idle = 0;
    for (int i = 0; i < 3; i++) field_sum[i] = 0;

    // Coincident pairs give a zero term, so these fields are zero outright.
    add_row(5, -7, 9, 5, -7, 9, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 1);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
    // Extreme positions, both ways, with extreme moments.
    add_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
            32'sh80000000, 32'sh80000000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 0);
    add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 16'sh8000, 16'sh8000, 16'sh8000, 1, 0);
    // One-LSB separations give huge terms and drive the sums into saturation.
    add_row(1, 0, 0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, 0, 16'sh7fff, 0, 0, 1, 0);
    add_row(0, 0, -1, 0, 0, 0, 0, 0, 16'sh8000, 0, 0);
    add_row(0, 0, -1, 0, 0, 0, 0, 0, 16'sh8000, 0, 0);
    add_row(0, 0, -1, 0, 0, 0, 0, 0, 16'sh8000, 1, 0);
    add_row(0, 1, 0, 0, 0, 0, 16'sh7fff, 0, 0, 1, 0);
    // A far source gives a term too small to reach the sums.
    add_row(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 1, 1, 1, 1, 0);
    // Separations and moments of moderate size.
    add_row(0, 0, 32'sh10000, 0, 0, 0, 0, 0, 16'sh1000, 0, 0);
    add_row(32'sh10000, 32'sh10000, 0, 0, 0, 0, 16'sh1000, -16'sh1000, 16'sh0800, 0, 0);
    add_row(-32'sh30000, 32'sh20000, 32'sh8000, 32'sh1000, 0, -32'sh4000,
            -16'sh2000, 16'sh0123, 16'sh7000, 0, 0);
    // A coincident last pair still delivers what came before it.
    add_row(3, 3, 3, 3, 3, 3, 16'sh1234, 16'sh4321, -16'sh1111, 1, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].want);
    pause_until_drained();

    snd_idle = 26;
    rcv_idle = 56;
    random_phase(130);
    pause_until_drained();
    snd_idle = 56;
    rcv_idle = 26;
    random_phase(130);
    pause_until_drained();
    snd_idle = 0;
    rcv_idle = 0;
    // The receiver stalls for a long stretch while requests keep coming.
    hold_req = 1'b1;
    random_phase(140);
    item_valid <= 1'b0;

    while (field_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS dipole_field_accumulator_unit");
    end else begin
      $display("FAIL dipole_field_accumulator_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dfa_pkg.sv
rtl/dfa_front.sv
rtl/dfa_fifo.sv
rtl/dfa_div.sv
rtl/dfa_back.sv
rtl/dipole_field_accumulator_unit.sv
tb/dipole_field_accumulator_unit_test.sv
